// ===== design/nau_pkg.sv =====
// ----------------------------------------------------------------------------
// nau_pkg
// Shared types, constants and the sigmoid table builder for the activation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nau_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned SIG_DEPTH = 256;
  localparam int unsigned DEPTH_W   = $clog2(SIG_DEPTH);
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned DEN_W     = 24;
  localparam int unsigned DEN_FRAC  = 12;
  localparam int unsigned SLOPE_W   = 13;
  localparam int unsigned SLOPE_FRAC = 12;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned TAB_W     = FRAC_BITS + 1;
  localparam int unsigned SPAN_W    = FRAC_BITS + 5;
  localparam int unsigned FL_W      = FRAC_BITS + 4 - DEPTH_W;
  localparam int unsigned NUM_W     = VAL_W + DEN_FRAC;
  localparam int unsigned LEAK_W    = VAL_W + SLOPE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDENT   = 3'd0,
    MODE_RELU    = 3'd1,
    MODE_LEAKY   = 3'd2,
    MODE_SIGMOID = 3'd3,
    MODE_TANH    = 3'd4,
    MODE_SOFTMAX = 3'd5
  } mode_e;

  typedef enum logic [0:0] {
    REG_MODE  = 1'b0,
    REG_SLOPE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [DEN_W-1:0]        denominator;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result;
    logic                    div_by_zero;
  } out_t;

  // item travelling down the divider chain
  typedef struct packed {
    logic                    div;
    logic                    neg;
    logic                    flag;
    logic signed [VAL_W-1:0] res;
    logic [DEN_W-1:0]        den;
    logic [DEN_W-1:0]        rem;
    logic [NUM_W-1:0]        num;
    logic [NUM_W-1:0]        quot;
  } lane_t;

  typedef logic [TAB_W-1:0] sig_tab_t [0:SIG_DEPTH];

  // shift-subtract quotient, elaboration only
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t          tab;
    longint unsigned   n;
    longint unsigned   term;
    longint unsigned   sum;
    longint unsigned   c;
    longint unsigned   s;
    longint            num_s;
    bit                stop;
    for (int k = 0; k <= int'(SIG_DEPTH); k++) begin
      num_s = 64'(16 * k) - 64'(8 * SIG_DEPTH);
      n     = (num_s < 0) ? 64'(-num_s) : 64'(num_s);
      term  = 64'd1 << 32;
      sum   = term;
      stop  = 1'b0;
      for (int j = 1; j <= 64; j++) begin
        if (!stop) begin
          term = udiv64(term * n, 64'(SIG_DEPTH) * 64'(j));
          if (term == 64'd0) begin
            stop = 1'b1;
          end else begin
            sum = sum + term;
          end
        end
      end
      c = (64'd1 << 32) + sum;
      s = udiv64((64'd1 << (FRAC_BITS + 32)) + (c >> 1), c);
      if (num_s < 0) begin
        tab[k] = TAB_W'(s);
      end else begin
        tab[k] = TAB_W'((64'd1 << FRAC_BITS) - s);
      end
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ===== design/nau_front.sv =====
// ----------------------------------------------------------------------------
// nau_front
// Input register, table lookup, multiplies and mode select; feeds the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire nau_pkg::in_t                  in_i,
  input  wire nau_pkg::mode_e                mode_i,
  input  wire logic [nau_pkg::SLOPE_W-1:0]   slope_i,
  output logic                               valid_o,
  output nau_pkg::lane_t                     lane_o
);

  localparam int unsigned F    = nau_pkg::FRAC_BITS;
  localparam int unsigned D    = nau_pkg::SIG_DEPTH;
  localparam int unsigned DW   = nau_pkg::DEPTH_W;
  localparam int unsigned VW   = nau_pkg::VAL_W;
  localparam int unsigned TW   = nau_pkg::TAB_W;
  localparam int unsigned FLW  = nau_pkg::FL_W;
  localparam int unsigned SW   = nau_pkg::SPAN_W;
  localparam int unsigned NW   = nau_pkg::NUM_W;
  localparam int unsigned LW   = nau_pkg::LEAK_W;
  localparam int unsigned AW   = VW + 1;
  localparam int unsigned UW   = ((F + 4 > AW) ? F + 4 : AW) + 2;
  localparam int unsigned LKW  = LW - nau_pkg::SLOPE_FRAC + 1;

  localparam nau_pkg::sig_tab_t SIG_TAB = nau_pkg::build_sig_tab();

  // stage 1
  logic                           v1_q;
  logic signed [VW-1:0]           x1_q;
  logic [nau_pkg::DEN_W-1:0]      den1_q;
  nau_pkg::mode_e                 mode1_q;
  logic [nau_pkg::SLOPE_W-1:0]    slope1_q;

  // stage 2
  logic                           v2_q;
  logic signed [VW-1:0]           x2_q;
  nau_pkg::mode_e                 mode2_q;
  logic                           dz2_q;
  logic [TW-1:0]                  lo2_q;
  logic [TW-1:0]                  diff2_q;
  logic [FLW-1:0]                 fl2_q;
  logic [LW-1:0]                  leak2_q;
  logic [NW-1:0]                  num2_q;
  logic [nau_pkg::DEN_W-1:0]      den2_q;

  logic                           v3_q;
  nau_pkg::lane_t                 lane_q;

  logic signed [AW-1:0]           arg;
  logic signed [UW-1:0]           ux;
  logic [SW-1:0]                  u;
  logic [DW:0]                    idx;
  logic [DW:0]                    idx_hi;
  logic [TW-1:0]                  lo;
  logic [TW-1:0]                  hi;
  logic [VW-1:0]                  mag;
  logic [TW+FLW-1:0]              prod;
  logic [TW-1:0]                  sig;
  logic [LKW-1:0]                 lk;
  logic signed [VW-1:0]           res;
  nau_pkg::lane_t                 lane_d;

  always_comb begin
    arg = (mode1_q == nau_pkg::MODE_TANH) ? {x1_q, 1'b0} : {x1_q[VW-1], x1_q};
    ux  = UW'(arg) + $signed(UW'(1) << (F + 3));
    if (ux < 0) begin
      u = '0;
    end else if (ux > $signed(UW'(1) << (F + 4))) begin
      u = SW'(1) << (F + 4);
    end else begin
      u = SW'(ux);
    end
    idx    = u[F+4 -: DW+1];
    idx_hi = (idx == (DW+1)'(D)) ? idx : idx + (DW+1)'(1);
    lo     = SIG_TAB[idx];
    hi     = SIG_TAB[idx_hi];
    mag    = x1_q[VW-1] ? VW'(-x1_q) : VW'(x1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q     <= in_i.value;
    den1_q   <= in_i.denominator;
    mode1_q  <= mode_i;
    slope1_q <= slope_i;

    x2_q    <= x1_q;
    mode2_q <= mode1_q;
    dz2_q   <= (den1_q == '0);
    lo2_q   <= lo;
    diff2_q <= hi - lo;
    fl2_q   <= u[FLW-1:0];
    leak2_q <= LW'(mag) * LW'(slope1_q);
    num2_q  <= NW'({mag, nau_pkg::DEN_FRAC'(0)}) + NW'(den1_q >> 1);
    den2_q  <= den1_q;

    lane_q  <= lane_d;
  end

  always_comb begin
    prod = (TW+FLW)'(diff2_q) * (TW+FLW)'(fl2_q);
    sig  = lo2_q + TW'((prod + ((TW+FLW)'(1) << (FLW - 1))) >> FLW);
    lk   = LKW'((leak2_q + (LW'(1) << (nau_pkg::SLOPE_FRAC - 1))) >> nau_pkg::SLOPE_FRAC);

    lane_d      = '0;
    lane_d.den  = den2_q;
    lane_d.num  = num2_q;
    lane_d.neg  = x2_q[VW-1];
    case (mode2_q)
      nau_pkg::MODE_RELU: begin
        res = x2_q[VW-1] ? '0 : x2_q;
      end
      nau_pkg::MODE_LEAKY: begin
        if (!x2_q[VW-1]) begin
          res = x2_q;
        end else if (lk > (LKW'(1) << (VW - 1))) begin
          res = {1'b1, {(VW-1){1'b0}}};
        end else begin
          res = VW'(-lk);
        end
      end
      nau_pkg::MODE_SIGMOID: begin
        res = VW'(sig);
      end
      nau_pkg::MODE_TANH: begin
        res = VW'({sig, 1'b0}) - (VW'(1) << F);
      end
      nau_pkg::MODE_SOFTMAX: begin
        res         = '0;
        lane_d.flag = dz2_q;
        lane_d.div  = !dz2_q;
      end
      default: begin
        res = x2_q;
      end
    endcase
    lane_d.res = res;
  end

  assign valid_o = v3_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

// ===== design/nau_div_cell.sv =====
// ----------------------------------------------------------------------------
// nau_div_cell
// One restoring-divide step: retires one quotient bit and passes the item on.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_div_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire nau_pkg::lane_t  lane_i,
  output logic                 valid_o,
  output nau_pkg::lane_t       lane_o
);

  localparam int unsigned RW = nau_pkg::DEN_W;
  localparam int unsigned NW = nau_pkg::NUM_W;

  logic                 valid_q;
  nau_pkg::lane_t       lane_q;
  nau_pkg::lane_t       lane_d;
  logic [RW:0]          r2;
  logic                 ge;

  always_comb begin
    r2     = {lane_i.rem, lane_i.num[NW-1]};
    ge     = (r2 >= {1'b0, lane_i.den});
    lane_d = lane_i;
    lane_d.rem  = ge ? RW'(r2 - {1'b0, lane_i.den}) : RW'(r2);
    lane_d.num  = {lane_i.num[NW-2:0], 1'b0};
    lane_d.quot = {lane_i.quot[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

// ===== design/neural_activation_unit_core.sv =====
// ----------------------------------------------------------------------------
// neural_activation_unit_core
// Per-value activation (identity, relu, leaky relu, sigmoid, tanh, softmax
// normalize) on signed Q4.12 data.
//
//   channel   ports                               transfer
//   input     start_i, busy_o, in_i               start_i high, busy_o low
//   result    done_o, out_o                       done_o high, one cycle
//   config    cfg_we_i, cfg_idx_i, cfg_data_i     cfg_we_i high
//
// One item per cycle; each result passes through the 3 front stages, 28 divider
// cells and the output register.
// The divider cell chain sets the latency: one quotient bit per cell.
// busy_o is always low; results cannot be stalled.
// Reset sets the mode to identity and the slope to 41, and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module neural_activation_unit_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire nau_pkg::in_t                  in_i,
  output logic                               done_o,
  output nau_pkg::out_t                      out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_idx_i,
  input  wire logic [nau_pkg::SLOPE_W-1:0]   cfg_data_i
);

  localparam int unsigned NW      = nau_pkg::NUM_W;
  localparam int unsigned VW      = nau_pkg::VAL_W;
  localparam int unsigned LATENCY = 3 + NW + 1;

  nau_pkg::mode_e               mode_q;
  logic [nau_pkg::SLOPE_W-1:0]  slope_q;

  logic                         chain_v [0:NW];
  nau_pkg::lane_t               chain_l [0:NW];

  logic                         done_q;
  nau_pkg::out_t                out_q;
  nau_pkg::out_t                out_d;
  nau_pkg::lane_t               last;
  logic                         accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= nau_pkg::MODE_IDENT;
      slope_q <= nau_pkg::SLOPE_W'(41);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nau_pkg::REG_MODE:  mode_q  <= nau_pkg::mode_e'(cfg_data_i[nau_pkg::MODE_W-1:0]);
        nau_pkg::REG_SLOPE: slope_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  nau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .mode_i  (mode_q),
    .slope_i (slope_q),
    .valid_o (chain_v[0]),
    .lane_o  (chain_l[0])
  );

  for (genvar g = 0; g < NW; g++) begin : g_cell
    nau_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[g]),
      .lane_i  (chain_l[g]),
      .valid_o (chain_v[g+1]),
      .lane_o  (chain_l[g+1])
    );
  end

  always_comb begin
    last              = chain_l[NW];
    out_d.div_by_zero = last.flag;
    if (!last.div) begin
      out_d.result = last.res;
    end else if (last.neg) begin
      if (last.quot > (NW'(1) << (VW - 1))) begin
        out_d.result = {1'b1, {(VW-1){1'b0}}};
      end else begin
        out_d.result = VW'(-last.quot[VW-1:0]);
      end
    end else begin
      if (last.quot > ((NW'(1) << (VW - 1)) - NW'(1))) begin
        out_d.result = {1'b0, {(VW-1){1'b1}}};
      end else begin
        out_d.result = VW'(last.quot);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_v[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("result missing after fixed latency");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, LATENCY)) |-> $past(accept, LATENCY))
    else $error("result without matching transfer");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_v[NW] && last.flag) |=> (done_o && out_o.result == '0 && !$past(last.div)))
    else $error("divide-by-zero result not cleared");

endmodule

`default_nettype wire
